>>> design/crt_pkg.sv
// crt_pkg: shared types and constants for the generalized crt combiner
package crt_pkg;

  localparam int unsigned ModBits = 62;
  localparam int unsigned W = 62;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StNoSol = 2'd1;
  localparam logic [1:0] StOvf   = 2'd2;

  localparam logic [W-1:0] ModLimit = {{(W-ModBits){1'b0}}, {ModBits{1'b1}}};

  typedef struct packed {
    logic [W-1:0] residue;
    logic [W-1:0] modulus;
    logic         last;
  } in_t;

  typedef struct packed {
    logic [W-1:0] solution;
    logic [W-1:0] combined_modulus;
    logic [1:0]   status;
  } out_t;

  // divider operation request and result
  typedef struct packed {
    logic         start;
    logic [W-1:0] num;
    logic [W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic         done;
    logic [W-1:0] quo;
    logic [W-1:0] rem;
  } div_rsp_t;

  // modular multiply request and result
  typedef struct packed {
    logic         start;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] n;
  } mm_req_t;

  typedef struct packed {
    logic         done;
    logic [W-1:0] res;
  } mm_rsp_t;

endpackage

>>> design/crt_general_combiner.sv
// crt_general_combiner: top level, merge sequencer over shared divider and mulmod
//
//  channel | dir | handshake           | payload
//  in      | in  | in_valid_i/ready_o  | in_i  (residue, modulus, last)
//  out     | out | out_valid_o/ready_i | out_o (solution, combined_modulus, status)
//
// each congruence is merged by a sequencer over one 62-step divider and one
// shift-add modular multiplier; a merge that passes every check runs 9 fixed
// divides, one divide per euclid step, one divide and one multiply per inverse
// step and three more multiplies; a failed check ends the merge early
// reset clears the running residue to 0, modulus to 1 and status to ok
// input is taken only in idle; a finished system waits in S_OUT while the
// previous result still sits unaccepted in the output register
module crt_general_combiner (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  crt_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output crt_pkg::out_t out_o
);
  import crt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_RED_A, S_GCD, S_GCD_W, S_AG, S_AG_W, S_RG, S_RG_W,
    S_MG, S_MG_W, S_LIM, S_LIM_W, S_NP, S_NP_W, S_MP, S_MP_W,
    S_DF, S_DF_W, S_DF2, S_DF2_W, S_INV, S_INV_W, S_INV_M, S_INV_MW,
    S_T, S_T_W, S_PM, S_PM_W, S_PR, S_PR_W, S_FIN, S_OUT
  } state_e;

  state_e       state_q;
  logic [W-1:0] accr_q, accm_q;
  logic [1:0]   fail_q;
  logic         last_q;
  logic [W-1:0] a_q, n_q, g_q, x_q, y_q, ag_q, mg_q, np_q, mp_q, df_q;
  logic [W-1:0] r0_q, r1_q, t0_q, t1_q, q_q;
  logic         neg_q;
  out_t         out_q;
  logic         ovalid_q;
  logic         out_load;
  div_req_t     dreq;
  div_rsp_t     drsp;
  mm_req_t      mreq;
  mm_rsp_t      mrsp;
  logic [W-1:0] dnum, dden, ma, mb, mn;
  logic         dgo, mgo;

  crt_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));
  crt_mulmod u_mm (.clk_i, .rst_ni, .req_i(mreq), .rsp_o(mrsp));

  // operand selection for the shared units
  always_comb begin
    dgo = 1'b0; dnum = '0; dden = W'(1);
    mgo = 1'b0; ma = '0; mb = '0; mn = W'(1);
    unique case (state_q)
      S_RED_A: begin dgo = 1'b1; dnum = a_q; dden = n_q; end
      S_GCD:   begin dgo = 1'b1; dnum = x_q; dden = y_q; end
      S_AG:    begin dgo = 1'b1; dnum = a_q; dden = g_q; end
      S_RG:    begin dgo = 1'b1; dnum = accr_q; dden = g_q; end
      S_MG:    begin dgo = 1'b1; dnum = accm_q; dden = g_q; end
      S_LIM:   begin dgo = 1'b1; dnum = ModLimit; dden = n_q; end
      S_NP:    begin dgo = 1'b1; dnum = n_q; dden = g_q; end
      S_MP:    begin dgo = 1'b1; dnum = mg_q; dden = np_q; end
      S_DF:    begin dgo = 1'b1; dnum = (a_q >= accr_q) ? a_q - accr_q : accr_q - a_q;
                     dden = g_q; end
      S_DF2:   begin dgo = 1'b1; dnum = df_q; dden = np_q; end
      S_INV:   begin dgo = 1'b1; dnum = r0_q; dden = r1_q; end
      S_INV_M: begin mgo = 1'b1; ma = q_q; mb = t1_q; mn = np_q; end
      S_T:     begin mgo = 1'b1; ma = df_q; mb = t0_q; mn = np_q; end
      S_PM:    begin mgo = 1'b1; ma = accm_q; mb = df_q; mn = ModLimit; end
      S_PR:    begin mgo = 1'b1; ma = accm_q; mb = np_q; mn = ModLimit; end
      default: ;
    endcase
  end
  assign dreq = '{start: dgo, num: dnum, den: dden};
  // quotient of r0/r1 is at most np, one conditional subtract reduces it
  assign mreq = '{start: mgo, a: ma, b: mb, n: mn};

  // in S_OUT, the result register loads when it is free or being taken
  assign out_load = (state_q == S_OUT) && (!ovalid_q || out_ready_i);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; accr_q <= '0; accm_q <= W'(1); fail_q <= StOk;
      ovalid_q <= 1'b0; last_q <= 1'b0; neg_q <= 1'b0; out_q <= '0;
      a_q <= '0; n_q <= '0; g_q <= '0; x_q <= '0; y_q <= '0;
      ag_q <= '0; mg_q <= '0; np_q <= '0; mp_q <= '0; df_q <= '0;
      r0_q <= '0; r1_q <= '0; t0_q <= '0; t1_q <= '0; q_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: if (in_valid_i) begin
          a_q <= in_i.residue; last_q <= in_i.last;
          n_q <= (in_i.modulus == '0) ? W'(1) : in_i.modulus;
          g_q <= '0; neg_q <= 1'b0;
          if (fail_q != StOk) state_q <= S_FIN;
          else if (in_i.modulus > ModLimit) begin
            fail_q <= StOvf; state_q <= S_FIN;
          end else state_q <= S_RED_A;
        end
        S_RED_A: state_q <= S_GCD_W;
        // first pass reduces a, then euclid on (m, n)
        S_GCD_W: if (drsp.done) begin
          if (g_q == '0) begin
            a_q <= drsp.rem; x_q <= accm_q; y_q <= n_q; g_q <= W'(1);
            state_q <= S_GCD;
          end else begin
            x_q <= y_q; y_q <= drsp.rem;
            if (drsp.rem == '0) begin g_q <= y_q; state_q <= S_AG; end
            else state_q <= S_GCD;
          end
        end
        S_GCD:  state_q <= S_GCD_W;
        S_AG:   state_q <= S_AG_W;
        S_AG_W: if (drsp.done) begin ag_q <= drsp.rem; state_q <= S_RG; end
        S_RG:   state_q <= S_RG_W;
        S_RG_W: if (drsp.done) begin
          if (drsp.rem != ag_q) begin fail_q <= StNoSol; state_q <= S_FIN; end
          else state_q <= S_MG;
        end
        S_MG:   state_q <= S_MG_W;
        S_MG_W: if (drsp.done) begin mg_q <= drsp.quo; state_q <= S_LIM; end
        S_LIM:  state_q <= S_LIM_W;
        S_LIM_W: if (drsp.done) begin
          if (mg_q > drsp.quo) begin fail_q <= StOvf; state_q <= S_FIN; end
          else state_q <= S_NP;
        end
        S_NP:   state_q <= S_NP_W;
        S_NP_W: if (drsp.done) begin np_q <= drsp.quo; state_q <= S_MP; end
        S_MP:   state_q <= S_MP_W;
        S_MP_W: if (drsp.done) begin mp_q <= drsp.rem; state_q <= S_DF; end
        S_DF:   begin neg_q <= (a_q < accr_q); state_q <= S_DF_W; end
        S_DF_W: if (drsp.done) begin df_q <= drsp.quo; state_q <= S_DF2; end
        S_DF2:  state_q <= S_DF2_W;
        S_DF2_W: if (drsp.done) begin
          df_q <= (neg_q && drsp.rem != '0) ? np_q - drsp.rem : drsp.rem;
          r0_q <= np_q; r1_q <= mp_q; t0_q <= '0;
          t1_q <= (np_q == W'(1)) ? '0 : W'(1);
          state_q <= (mp_q == '0) ? S_T : S_INV;
        end
        S_INV:   state_q <= S_INV_W;
        S_INV_W: if (drsp.done) begin
          // quotient is at most np, one subtract reduces it
          q_q <= (drsp.quo >= np_q) ? drsp.quo - np_q : drsp.quo;
          r0_q <= r1_q; r1_q <= drsp.rem; state_q <= S_INV_M;
        end
        S_INV_M:  state_q <= S_INV_MW;
        S_INV_MW: if (mrsp.done) begin
          t0_q <= t1_q;
          t1_q <= (t0_q >= mrsp.res) ? t0_q - mrsp.res : t0_q + (np_q - mrsp.res);
          state_q <= (r1_q == '0) ? S_T : S_INV;
        end
        S_T:   state_q <= S_T_W;
        S_T_W: if (mrsp.done) begin
          df_q <= mrsp.res; state_q <= S_PM; neg_q <= 1'b1;
        end
        // m * t stays below the range limit, so the modulus leaves it exact
        S_PM:   state_q <= S_PM_W;
        S_PM_W: if (mrsp.done) begin df_q <= mrsp.res; state_q <= S_PR; end
        // m * np is nonzero and at most the limit, zero means exactly the limit
        S_PR:   state_q <= S_PR_W;
        S_PR_W: if (mrsp.done) begin
          np_q <= (mrsp.res == '0) ? ModLimit : mrsp.res; state_q <= S_FIN;
        end
        S_FIN: begin
          if (fail_q == StOk && neg_q) begin
            accr_q <= accr_q + df_q; accm_q <= np_q;
          end
          neg_q <= 1'b0;
          state_q <= last_q ? S_OUT : S_IDLE;
        end
        S_OUT: if (out_load) begin
          out_q.status <= fail_q;
          out_q.solution <= (fail_q == StOk) ? accr_q : '0;
          out_q.combined_modulus <= (fail_q == StOk) ? accm_q : '0;
          accr_q <= '0; accm_q <= W'(1); fail_q <= StOk;
          state_q <= S_IDLE;
        end
        default: ;
      endcase
      // output valid: set on load, cleared on acceptance
      if (out_load) ovalid_q <= 1'b1;
      else if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;
  assign out_o       = out_q;

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE) else $error("ready outside idle");
  a_out_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (fail_q == StOk && accm_q == W'(1)))
    else $error("state not cleared after result");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.status != StOk) |-> out_o.combined_modulus == '0)
    else $error("failed result carries modulus");
`endif
endmodule

>>> design/crt_div.sv
// crt_div: restoring divider, one quotient bit per cycle
module crt_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  crt_pkg::div_req_t req_i,
  output crt_pkg::div_rsp_t rsp_o
);
  import crt_pkg::*;

  logic [W-1:0] quo_q, quo_d, den_q, den_d;
  logic [W:0]   rem_q, rem_d;
  logic [5:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d, done_q, done_d;
  logic [W:0]   shifted;

  // one shift and trial subtract per cycle
  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    shifted = {rem_q[W-1:0], quo_q[W-1]};
    if (req_i.start) begin
      quo_d = req_i.num; rem_d = '0; den_d = req_i.den;
      cnt_d = 6'(W - 1); busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_d = shifted - {1'b0, den_q};
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q[W-1:0];

`ifndef ASSERT_OFF
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q) else $error("divider did not start");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q <= 6'(W - 1)) else $error("divider count out of range");
`endif
endmodule

>>> design/crt_mulmod.sv
// crt_mulmod: shift-and-add modular multiplier, one bit of b per cycle
module crt_mulmod (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  crt_pkg::mm_req_t req_i,
  output crt_pkg::mm_rsp_t rsp_o
);
  import crt_pkg::*;

  logic [W-1:0] a_q, a_d, b_q, b_d, n_q, n_d, r_q, r_d;
  logic         busy_q, busy_d, done_q, done_d;
  logic [W:0]   sum, dbl;

  // operands are to arrive reduced below n; the block itself does not enforce it
  always_comb begin
    a_d = a_q; b_d = b_q; n_d = n_q; r_d = r_q;
    busy_d = busy_q; done_d = 1'b0;
    sum = {1'b0, r_q} + {1'b0, a_q};
    dbl = {a_q, 1'b0};
    if (req_i.start) begin
      a_d = req_i.a; b_d = req_i.b; n_d = req_i.n; r_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q == '0) begin
        busy_d = 1'b0; done_d = 1'b1;
      end else begin
        if (b_q[0]) r_d = (sum >= {1'b0, n_q}) ? W'(sum - {1'b0, n_q}) : sum[W-1:0];
        a_d = (dbl >= {1'b0, n_q}) ? W'(dbl - {1'b0, n_q}) : dbl[W-1:0];
        b_d = b_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0;
    end else begin
      busy_q <= busy_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; n_q <= n_d; r_q <= r_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = r_q;

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("mulmod done while busy");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q) else $error("mulmod did not start");
  a_res_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (r_q < n_q || n_q == '0)) else $error("mulmod result not reduced");
`endif
endmodule
